FILE: hdl/b58h_pkg.sv
// b58h_pkg: shared types, constants and lookup functions for the base58 to hex converter
// no dependencies; used by b58h_cell, b58h_mac and base58_to_hex_converter
`timescale 1ns / 1ps

package b58h_pkg;

   // default sizes
   localparam int HEX_DIGITS_DEF  = 48;
   localparam int MAX_SYMBOLS_DEF = 32;

   // symbol counter width, covers the full symbol limit range
   localparam int COUNT_W = 6;

   // base58 radix and digit widths
   localparam int RADIX     = 58;
   localparam int DIGIT_W   = 4;
   localparam int CARRY_W   = 6;
   localparam int PRODUCT_W = DIGIT_W + CARRY_W;

   // ascii codes used on the result channel
   localparam logic [7:0] ASCII_NEWLINE = 8'h0A;
   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_NONE    = 8'h00;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_SYMBOL  = 2'd1,
      STATUS_TOO_LONG    = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_MUL,
      CTL_DUMP,
      CTL_TAIL
   } ctl_state_type;

   // control group broadcast to every cell
   typedef struct packed {
      logic clear;
      logic shift_dn;
      logic shift_up;
   } cell_ctl_type;

   // result of the alphabet lookup
   typedef struct packed {
      logic               ok;
      logic [CARRY_W-1:0] value;
   } digit_lookup_type;

   // map an ascii symbol to its base58 digit
   function automatic digit_lookup_type base58_digit(input logic [7:0] sym);
      digit_lookup_type res;
      logic [7:0]       val;
      res = '0;
      val = 8'd0;
      if (sym >= "1" && sym <= "9") begin
         val = sym - 8'h31;
         res.ok = 1'b1;
      end else if (sym >= "A" && sym <= "H") begin
         val = sym - 8'h41 + 8'd9;
         res.ok = 1'b1;
      end else if (sym >= "J" && sym <= "N") begin
         val = sym - 8'h4A + 8'd17;
         res.ok = 1'b1;
      end else if (sym >= "P" && sym <= "Z") begin
         val = sym - 8'h50 + 8'd22;
         res.ok = 1'b1;
      end else if (sym >= "a" && sym <= "k") begin
         val = sym - 8'h61 + 8'd33;
         res.ok = 1'b1;
      end else if (sym >= "m" && sym <= "z") begin
         val = sym - 8'h6D + 8'd44;
         res.ok = 1'b1;
      end
      res.value = val[CARRY_W-1:0];
      return res;
   endfunction

   // lowercase ascii for one hex digit
   function automatic logic [7:0] hex_ascii(input logic [DIGIT_W-1:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h57 + {4'd0, nib};
      end
      return ch;
   endfunction

endpackage

FILE: hdl/base58_to_hex_converter.sv
// a symbol beat passes every cell, one cell per cycle,
//   through the shared multiply-add at the bottom of the cell chain
// end beat: the digits are shifted out, then the tail gives a zero digit for a zero value and the newline,
//   each gated by the result register; each result appears in the result register in the cycle after its step
// a new symbol is taken only once the previous one has passed every cell; error results need no pass
// reset: synchronous, clears the store, counter, discard flag and the result valid flag
`timescale 1ns / 1ps

module base58_to_hex_converter #(
   parameter int HEX_DIGITS  = b58h_pkg::HEX_DIGITS_DEF,
   parameter int MAX_SYMBOLS = b58h_pkg::MAX_SYMBOLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_symbol,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_hex_char,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   localparam int IDX_W = $clog2(HEX_DIGITS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEX_DIGITS - 1);
   localparam int DW = b58h_pkg::DIGIT_W;

   // controller registers
   b58h_pkg::ctl_state_type            state_ff, state_in;
   logic [IDX_W-1:0]                   idx_ff, idx_in;
   logic [b58h_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                               discard_ff, discard_in;
   logic                               seen_ff, seen_in;
   logic [b58h_pkg::CARRY_W-1:0]       carry_ff, carry_in;

   // result register
   logic                               rsp_valid_ff;
   logic [7:0]                         rsp_hex_char_ff;
   b58h_pkg::status_type               rsp_status_ff;
   logic                               rsp_last_ff;

   logic                               out_free;
   logic                               accept;
   logic                               emit;
   logic [7:0]                         emit_char;
   b58h_pkg::status_type               emit_status;
   logic                               emit_last;

   b58h_pkg::cell_ctl_type             cell_ctl;
   b58h_pkg::digit_lookup_type         lookup;
   logic [DW-1:0]                      digit_w [HEX_DIGITS];
   logic [DW-1:0]                      mac_digit;
   logic [b58h_pkg::CARRY_W-1:0]       mac_carry;
   logic [DW-1:0]                      top_digit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != b58h_pkg::CTL_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign lookup    = b58h_pkg::base58_digit(req_symbol);
   assign top_digit = digit_w[HEX_DIGITS-1];

   // shared multiply-add at the low end of the chain
   b58h_mac u_mac (
      .digit_in  (digit_w[0]),
      .carry_in  (carry_ff),
      .digit_out (mac_digit),
      .carry_out (mac_carry)
   );

   // row of digit cells, least significant at index zero
   for (genvar i = 0; i < HEX_DIGITS; i++) begin : g_cell
      logic [DW-1:0] above;
      logic [DW-1:0] below;
      if (i == HEX_DIGITS - 1) begin : g_top
         assign above = mac_digit;
      end else begin : g_mid_top
         assign above = digit_w[i+1];
      end
      if (i == 0) begin : g_bottom
         assign below = '0;
      end else begin : g_mid_bottom
         assign below = digit_w[i-1];
      end
      b58h_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .from_above (above),
         .from_below (below),
         .digit      (digit_w[i])
      );
   end

   // controller state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= b58h_pkg::CTL_IDLE;
         idx_ff     <= '0;
         count_ff   <= '0;
         discard_ff <= 1'b0;
         seen_ff    <= 1'b0;
         carry_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         count_ff   <= count_in;
         discard_ff <= discard_in;
         seen_ff    <= seen_in;
         carry_ff   <= carry_in;
      end
   end

   // next state, cell control and result beats
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      discard_in  = discard_ff;
      seen_in     = seen_ff;
      carry_in    = carry_ff;
      cell_ctl    = '0;
      emit        = 1'b0;
      emit_char   = b58h_pkg::ASCII_NONE;
      emit_status = b58h_pkg::STATUS_OK;
      emit_last   = 1'b0;
      unique case (state_ff)
         b58h_pkg::CTL_IDLE: begin
            if (accept) begin
               priority if (req_end_of_text && discard_ff) begin
                  // drop the string, start clean
                  cell_ctl.clear = 1'b1;
                  count_in       = '0;
                  discard_in     = 1'b0;
               end else if (req_end_of_text) begin
                  state_in = b58h_pkg::CTL_DUMP;
                  idx_in   = '0;
                  seen_in  = 1'b0;
               end else if (discard_ff) begin
                  // symbols after an error are ignored
               end else if (!lookup.ok) begin
                  emit        = 1'b1;
                  emit_status = b58h_pkg::STATUS_BAD_SYMBOL;
                  emit_last   = 1'b1;
                  discard_in  = 1'b1;
               end else if (count_ff >= b58h_pkg::COUNT_W'(MAX_SYMBOLS)) begin
                  emit        = 1'b1;
                  emit_status = b58h_pkg::STATUS_TOO_LONG;
                  emit_last   = 1'b1;
                  discard_in  = 1'b1;
               end else begin
                  state_in = b58h_pkg::CTL_MUL;
                  idx_in   = '0;
                  carry_in = lookup.value;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         b58h_pkg::CTL_MUL: begin
            // rotate the chain down, new digit enters at the top
            cell_ctl.shift_dn = 1'b1;
            carry_in          = mac_carry;
            idx_in            = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = b58h_pkg::CTL_IDLE;
               idx_in   = '0;
            end
         end
         b58h_pkg::CTL_DUMP: begin
            // shift out most significant first, zeros fill from the bottom
            if (out_free) begin
               cell_ctl.shift_up = 1'b1;
               if (seen_ff || (top_digit != '0)) begin
                  emit      = 1'b1;
                  emit_char = b58h_pkg::hex_ascii(top_digit);
                  seen_in   = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = b58h_pkg::CTL_TAIL;
                  idx_in   = '0;
               end
            end
         end
         b58h_pkg::CTL_TAIL: begin
            // zero value gets a single digit, then the newline closes the run
            if (out_free) begin
               emit = 1'b1;
               if (!seen_ff) begin
                  emit_char = b58h_pkg::ASCII_ZERO;
                  seen_in   = 1'b1;
               end else begin
                  emit_char  = b58h_pkg::ASCII_NEWLINE;
                  emit_last  = 1'b1;
                  count_in   = '0;
                  discard_in = 1'b0;
                  state_in   = b58h_pkg::CTL_IDLE;
               end
            end
         end
         default: begin
            state_in = b58h_pkg::CTL_IDLE;
         end
      endcase
   end

   // result register, loads whenever the downstream side can take a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_hex_char_ff <= emit_char;
         rsp_status_ff   <= emit_status;
         rsp_last_ff     <= emit_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hex_char = rsp_hex_char_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: hdl/b58h_cell.sv
// b58h_cell: one hex digit of the big number, shifts toward either neighbor
// depends on b58h_pkg
`timescale 1ns / 1ps

module b58h_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  b58h_pkg::cell_ctl_type           ctl,
   input  logic [b58h_pkg::DIGIT_W-1:0]     from_above,
   input  logic [b58h_pkg::DIGIT_W-1:0]     from_below,
   output logic [b58h_pkg::DIGIT_W-1:0]     digit
);

   logic [b58h_pkg::DIGIT_W-1:0] digit_ff;
   logic [b58h_pkg::DIGIT_W-1:0] digit_in;

   // pick the neighbor that feeds this cell
   always_comb begin
      priority if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.shift_dn) begin
         digit_in = from_above;
      end else if (ctl.shift_up) begin
         digit_in = from_below;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

   assign digit = digit_ff;

endmodule

FILE: hdl/b58h_mac.sv
// b58h_mac: digit times 58 plus carry, split into new digit and carry
// depends on b58h_pkg
`timescale 1ns / 1ps

module b58h_mac (
   input  logic [b58h_pkg::DIGIT_W-1:0]  digit_in,
   input  logic [b58h_pkg::CARRY_W-1:0]  carry_in,
   output logic [b58h_pkg::DIGIT_W-1:0]  digit_out,
   output logic [b58h_pkg::CARRY_W-1:0]  carry_out
);

   logic [b58h_pkg::PRODUCT_W-1:0] product;

   // max is 15*58+57, fits in ten bits
   assign product = ({{b58h_pkg::CARRY_W{1'b0}}, digit_in}
                     * b58h_pkg::PRODUCT_W'(b58h_pkg::RADIX))
                  + {{b58h_pkg::DIGIT_W{1'b0}}, carry_in};

   assign digit_out = product[b58h_pkg::DIGIT_W-1:0];
   assign carry_out = product[b58h_pkg::PRODUCT_W-1:b58h_pkg::DIGIT_W];

endmodule

FILE: verif/base58_to_hex_converter_test.sv
// base58_to_hex_converter_test: self-checking bench for the base58 text to hex converter
// depends on b58h_pkg and base58_to_hex_converter; drives symbol beats, predicts hex output
`timescale 1ns / 1ps

module base58_to_hex_converter_test;

   localparam int HEX_DIGITS  = b58h_pkg::HEX_DIGITS_DEF;
   localparam int MAX_SYMBOLS = b58h_pkg::MAX_SYMBOLS_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam string B58_ALPHABET =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
   localparam string HEX_ALPHABET = "0123456789abcdef";

   typedef struct packed {
      logic [7:0]           hex_char;
      b58h_pkg::status_type status;
      logic                 last;
   } hex_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_symbol = 8'd0;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_hex_char;
   logic [1:0] rsp_status;
   logic       rsp_last;

   // predictor state: the big number, least significant hex digit first
   logic [3:0]   num_digits [HEX_DIGITS];
   int           symbols_taken;
   logic         dropping;
   hex_beat_type expected_hex_beats [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count = 0;
   int beats_sent = 0;
   int strings_sent = 0;
   int hex_beats_seen = 0;
   int error_beats_seen = 0;
   int quiet_cycles = 0;

   base58_to_hex_converter #(
      .HEX_DIGITS  (HEX_DIGITS),
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hex_char    (rsp_hex_char),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // base58 digit of a symbol, -1 when it is not in the alphabet
   function automatic int b58_value(input logic [7:0] sym);
      int idx;
      for (idx = 0; idx < 58; idx++) begin
         if (B58_ALPHABET[idx] == sym) begin
            return idx;
         end
      end
      return -1;
   endfunction

   function automatic logic [7:0] random_b58_symbol();
      return B58_ALPHABET[$urandom_range(57)];
   endfunction

   function automatic logic [7:0] random_bad_symbol();
      logic [7:0] sym;
      sym = 8'($urandom_range(255));
      while (b58_value(sym) >= 0) begin
         sym = 8'($urandom_range(255));
      end
      return sym;
   endfunction

   function automatic void clear_number();
      int idx;
      for (idx = 0; idx < HEX_DIGITS; idx++) begin
         num_digits[idx] = 4'd0;
      end
      symbols_taken = 0;
      dropping = 1'b0;
   endfunction

   // append one expected result beat at the tail of the queue
   function automatic void expect_beat(input logic [7:0] ch,
                                       input b58h_pkg::status_type st,
                                       input logic is_last);
      hex_beat_type beat;
      beat.hex_char = ch;
      beat.status   = st;
      beat.last     = is_last;
      expected_hex_beats = {expected_hex_beats, beat};
   endfunction

   // advance the predicted number by one accepted beat, queue the hex beats it causes
   function automatic void decode_beat(input logic [7:0] sym, input logic eot);
      int idx;
      int top;
      int digit;
      int carry;
      int prod;
      if (eot) begin
         if (dropping) begin
            clear_number();
            return;
         end
         top = -1;
         for (idx = HEX_DIGITS - 1; idx >= 0 && top < 0; idx--) begin
            if (num_digits[idx] != 4'd0) begin
               top = idx;
            end
         end
         // zero value prints a single zero digit
         if (top < 0) begin
            expect_beat(b58h_pkg::ASCII_ZERO, b58h_pkg::STATUS_OK, 1'b0);
         end
         for (idx = top; idx >= 0; idx--) begin
            expect_beat(HEX_ALPHABET[num_digits[idx]], b58h_pkg::STATUS_OK, 1'b0);
         end
         expect_beat(b58h_pkg::ASCII_NEWLINE, b58h_pkg::STATUS_OK, 1'b1);
         clear_number();
         return;
      end
      if (dropping) begin
         return;
      end
      digit = b58_value(sym);
      if (digit < 0) begin
         dropping = 1'b1;
         expect_beat(b58h_pkg::ASCII_NONE, b58h_pkg::STATUS_BAD_SYMBOL, 1'b1);
         return;
      end
      if (symbols_taken >= MAX_SYMBOLS) begin
         dropping = 1'b1;
         expect_beat(b58h_pkg::ASCII_NONE, b58h_pkg::STATUS_TOO_LONG, 1'b1);
         return;
      end
      // multiply by 58 and add, carry ripples base 16; top carry is lost
      carry = digit;
      for (idx = 0; idx < HEX_DIGITS; idx++) begin
         prod = num_digits[idx] * 58 + carry;
         num_digits[idx] = prod[3:0];
         carry = prod >> 4;
      end
      symbols_taken++;
   endfunction

   // send one beat, with random idle cycles before it; returns once accepted
   task automatic send_beat(input logic [7:0] sym, input logic eot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_symbol <= 8'($urandom_range(255));
         req_end_of_text <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_symbol <= sym;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      decode_beat(sym, eot);
      beats_sent++;
      if (eot) begin
         strings_sent++;
      end
   endtask

   // stop sending and let every expected beat arrive
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_hex_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (HEX_DIGITS + 8) @(posedge clock);
   endtask

   task automatic send_text(input string text);
      int idx;
      for (idx = 0; idx < text.len(); idx++) begin
         send_beat(text[idx], 1'b0);
      end
      send_beat(8'($urandom_range(255)), 1'b1);
   endtask

   // empty string and strings of leading ones both give zero
   task automatic test_zero_value();
      send_beat(8'h00, 1'b1);
      send_text("1");
      send_text("111");
   endtask

   // largest digit alone, and a carry into a second hex digit
   task automatic test_digit_extremes();
      send_text("z");
      send_text("21");
      send_text("1z");
   endtask

   // bad symbols raise an error and the rest of the string is dropped
   task automatic test_bad_symbols();
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat("z", 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat("z", 1'b0);
      send_beat("0", 1'b0);
      send_beat("A", 1'b0);
      send_beat(8'h00, 1'b1);
      send_text("I");
      send_text("O");
      send_text("l");
   endtask

   // random strings: mostly well formed, some at or over the symbol limit, some broken
   task automatic test_random_strings(input int beat_budget);
      int first_beat;
      int pick;
      int len;
      int bad_at;
      int lead_ones;
      bit all_top;
      int idx;
      first_beat = beats_sent;
      while (beats_sent - first_beat < beat_budget) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            len = $urandom_range(10, 1);
         end else if (pick < 70) begin
            len = MAX_SYMBOLS;
         end else if (pick < 80) begin
            len = $urandom_range(MAX_SYMBOLS + 3, MAX_SYMBOLS + 1);
         end else begin
            len = $urandom_range(3, 0);
         end
         bad_at = ($urandom_range(99) < 15) ? $urandom_range(len, 0) : -1;
         lead_ones = ($urandom_range(99) < 20) ? $urandom_range(3, 1) : 0;
         all_top = ($urandom_range(99) < 25);
         for (idx = 0; idx < len; idx++) begin
            if (idx == bad_at) begin
               send_beat(random_bad_symbol(), 1'b0);
            end else if (idx < lead_ones) begin
               send_beat("1", 1'b0);
            end else if (all_top) begin
               send_beat("z", 1'b0);
            end else begin
               send_beat(random_b58_symbol(), 1'b0);
            end
         end
         send_beat(8'($urandom_range(255)), 1'b1);
      end
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      hex_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hex_beats.size() == 0) begin
            $error("unexpected beat: hex_char %h status %0d last %0b",
                   rsp_hex_char, rsp_status, rsp_last);
            fail_count++;
         end else begin
            want = expected_hex_beats.pop_front();
            hex_beats_seen++;
            if (want.status != b58h_pkg::STATUS_OK) begin
               error_beats_seen++;
            end
            if (rsp_hex_char !== want.hex_char) begin
               $error("hex_char: expected %h, got %h", want.hex_char, rsp_hex_char);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("base58_to_hex_converter_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_number();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, no idling
      test_zero_value();
      test_digit_extremes();
      test_bad_symbols();
      drain();

      // random part under each idling mix
      test_random_strings(15);
      drain();
      send_idle_pct = 54;
      test_random_strings(15);
      drain();
      send_idle_pct = 0;
      rsp_stall_pct = 54;
      test_random_strings(15);
      drain();
      send_idle_pct = 33;
      rsp_stall_pct = 33;
      test_random_strings(15);
      drain();

      $display("covered %0d strings in %0d input beats, %0d result beats checked",
               strings_sent, beats_sent, hex_beats_seen);
      $display("%0d error results, idling mixes none, sender, receiver and both",
               error_beats_seen);
      if (fail_count == 0 && expected_hex_beats.size() == 0) begin
         $display("base58_to_hex_converter_test: PASS");
      end else begin
         $display("base58_to_hex_converter_test: FAIL");
      end
      $finish;
   end

endmodule
